@@ rtl/fsr_pkg.sv @@
// shared types and constants for the binary32 square root / reciprocal square root unit
package fsr_pkg;

	// digit steps of the root and quotient pipelines
	localparam int ROOT_STEPS = 54;
	localparam int DIV_STEPS  = 56;

	localparam logic [31:0] QNAN_BITS  = 32'h7FC0_0000;
	localparam logic [31:0] QUIET_BIT  = 32'h0040_0000;
	localparam logic [31:0] INF_BITS   = 32'h7F80_0000;

	// unbiased exponent with headroom
	typedef logic signed [9:0] exp_t;

	// control that travels with every beat
	typedef struct packed {
		logic        last;
		logic        mode;
		logic        done;
		logic [31:0] res;
	} ctl_t;

endpackage

@@ rtl/float_sqrt_rsqrt_unit_core.sv @@
// top level of the binary32 square root / reciprocal square root unit
//
//  channel | beat fields (low bit first)                   | direction
//  s_*     | tdata: operand_bits, tuser: mode, tlast: last | in
//  m_*     | tdata: result_bits, tlast: last_out           | out
//
// one beat per cycle while the skid is not full
// the path runs through the 54-stage root and the 56-stage quotient pipelines
// arst_n clears all valid bits; payload registers are not reset
// the pipeline advances as one; a two-entry output register and skid stage
// let it move while a result waits, and it stops only when the skid is full
module float_sqrt_rsqrt_unit_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // operand_bits
	input  logic        s_tuser,   // mode
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // result_bits
	output logic        m_tlast
);

	logic            en;
	logic            u_valid;
	fsr_pkg::ctl_t   u_ctl;
	logic [25:0]     u_m;
	fsr_pkg::exp_t   u_ex;
	logic            r_valid;
	fsr_pkg::ctl_t   r_ctl;
	logic [52:0]     r_s;
	fsr_pkg::exp_t   r_es;
	logic            p_valid;
	logic            p_last;
	logic [31:0]     p_res;
	logic            skid_v_q;
	logic [31:0]     skid_res_q;
	logic            skid_last_q;

	assign en       = !skid_v_q;
	assign s_tready = en;

	fsr_unpack u_unpack (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.x         (s_tdata),
		.mode      (s_tuser),
		.last      (s_tlast),
		.out_valid (u_valid),
		.out_ctl   (u_ctl),
		.out_m     (u_m),
		.out_ex    (u_ex)
	);

	fsr_root u_root (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (u_valid),
		.in_ctl    (u_ctl),
		.in_m      (u_m),
		.in_ex     (u_ex),
		.out_valid (r_valid),
		.out_ctl   (r_ctl),
		.out_s     (r_s),
		.out_es    (r_es)
	);

	fsr_recip u_recip (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (r_valid),
		.in_ctl    (r_ctl),
		.in_s      (r_s),
		.in_es     (r_es),
		.out_valid (p_valid),
		.out_last  (p_last),
		.out_res   (p_res)
	);

	// output register with skid stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!m_tvalid || m_tready) begin
			if (skid_v_q) begin
				m_tvalid <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				m_tvalid <= p_valid;
			end
		end else if (p_valid && en) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!m_tvalid || m_tready) begin
			if (skid_v_q) begin
				m_tdata <= skid_res_q;
				m_tlast <= skid_last_q;
			end else begin
				m_tdata <= p_res;
				m_tlast <= p_last;
			end
		end else if (p_valid && en) begin
			skid_res_q  <= p_res;
			skid_last_q <= p_last;
		end
	end

	// a filled skid always sits behind a valid output beat
	assert property (@(posedge clk) disable iff (!arst_n) skid_v_q |-> m_tvalid)
		else $error("skid holds a beat while the output register is empty");

	// a skid beat stays put until the output drains
	assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && !m_tready) |=> (skid_v_q && $stable(skid_res_q)))
		else $error("skid beat lost during a stall");

	// no beat enters while the skid is full
	assert property (@(posedge clk) disable iff (!arst_n)
		(skid_v_q && !m_tready) |=> $stable(p_res))
		else $error("pipeline moved while the skid was full");

endmodule

@@ rtl/fsr_unpack.sv @@
// operand classification and subnormal normalization, two stages
module fsr_unpack (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [31:0]     x,
	input  logic            mode,
	input  logic            last,
	output logic            out_valid,
	output fsr_pkg::ctl_t   out_ctl,
	output logic [25:0]     out_m,
	output fsr_pkg::exp_t   out_ex
);

	logic            v_s1;
	fsr_pkg::ctl_t   ctl_s1;
	logic [22:0]     f_s1;
	logic [7:0]      e_s1;
	logic [4:0]      lz_s1;
	fsr_pkg::ctl_t   ctl_c;
	logic [4:0]      lz_c;
	logic            found_c;
	logic [23:0]     w_c;

	// special cases and leading zero count
	always_comb begin
		ctl_c.last = last;
		ctl_c.mode = mode;
		ctl_c.done = 1'b1;
		ctl_c.res  = '0;
		priority if (x[30:23] == 8'hFF && x[22:0] != 23'd0) begin
			ctl_c.res = x | fsr_pkg::QUIET_BIT;
		end else if (x[30:0] == 31'd0) begin
			ctl_c.res = mode ? {x[31], fsr_pkg::INF_BITS[30:0]} : x;
		end else if (x[31]) begin
			ctl_c.res = fsr_pkg::QNAN_BITS;
		end else if (x[30:23] == 8'hFF) begin
			ctl_c.res = mode ? 32'd0 : fsr_pkg::INF_BITS;
		end else begin
			ctl_c.done = 1'b0;
		end
		w_c     = {1'b0, x[22:0]};
		lz_c    = '0;
		found_c = 1'b0;
		for (int i = 23; i >= 0; i--) begin
			if (!found_c && w_c[i]) begin
				lz_c    = 5'(23 - i);
				found_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl_c;
			f_s1   <= x[22:0];
			e_s1   <= x[30:23];
			lz_s1  <= lz_c;
		end
	end

	logic [23:0]     m_c;
	fsr_pkg::exp_t   e0_c;
	fsr_pkg::exp_t   eev_c;
	logic [25:0]     mm_c;

	// shift to a leading one, make the exponent even
	always_comb begin
		if (e_s1 == 8'd0) begin
			m_c  = {1'b0, f_s1} << lz_s1;
			e0_c = -10'sd149 - $signed({5'd0, lz_s1});
		end else begin
			m_c  = {1'b1, f_s1};
			e0_c = $signed({2'b00, e_s1}) - 10'sd150;
		end
		if (e0_c[0]) begin
			mm_c  = {1'b0, m_c, 1'b0};
			eev_c = e0_c - 10'sd1;
		end else begin
			mm_c  = {m_c, 2'b00};
			eev_c = e0_c - 10'sd2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_ctl <= ctl_s1;
			out_m   <= mm_c;
			out_ex  <= eev_c >>> 1;
		end
	end

endmodule

@@ rtl/fsr_root.sv @@
// digit-by-digit square root pipeline, one root bit per stage, then rounding to 53 bits
module fsr_root (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  fsr_pkg::ctl_t   in_ctl,
	input  logic [25:0]     in_m,
	input  fsr_pkg::exp_t   in_ex,
	output logic            out_valid,
	output fsr_pkg::ctl_t   out_ctl,
	output logic [52:0]     out_s,
	output fsr_pkg::exp_t   out_es
);

	localparam int N = fsr_pkg::ROOT_STEPS;

	logic            v_s   [N];
	fsr_pkg::ctl_t   ctl_s [N];
	logic [25:0]     m_s   [N];
	fsr_pkg::exp_t   ex_s  [N];
	logic [56:0]     rem_s [N];
	logic [53:0]     root_s[N];

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam int J = N - 1 - k;
		logic            pv;
		fsr_pkg::ctl_t   pctl;
		logic [25:0]     pm;
		fsr_pkg::exp_t   pex;
		logic [56:0]     prem;
		logic [53:0]     proot;
		logic [1:0]      pair;
		logic [56:0]     acc;
		logic [56:0]     trial;

		if (k == 0) begin : g_first
			assign pv    = in_valid;
			assign pctl  = in_ctl;
			assign pm    = in_m;
			assign pex   = in_ex;
			assign prem  = '0;
			assign proot = '0;
		end else begin : g_next
			assign pv    = v_s[k-1];
			assign pctl  = ctl_s[k-1];
			assign pm    = m_s[k-1];
			assign pex   = ex_s[k-1];
			assign prem  = rem_s[k-1];
			assign proot = root_s[k-1];
		end

		// radicand pairs come from the operand, the rest are zero
		if (J >= 41) begin : g_pair
			assign pair = pm[2*(J-41)+1 -: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end

		assign acc   = {prem[54:0], pair};
		assign trial = {1'b0, proot, 2'b01};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		// one compare and subtract per stage
		always_ff @(posedge clk) begin
			if (en) begin
				ctl_s[k] <= pctl;
				m_s[k]   <= pm;
				ex_s[k]  <= pex;
				if (acc >= trial) begin
					rem_s[k]  <= acc - trial;
					root_s[k] <= {proot[52:0], 1'b1};
				end else begin
					rem_s[k]  <= acc;
					root_s[k] <= {proot[52:0], 1'b0};
				end
			end
		end
	end

	logic [53:0]     r_c;
	logic            inc_c;
	logic [53:0]     sum_c;

	// round the 54-bit root to 53 bits, nearest-even
	always_comb begin
		r_c   = root_s[N-1];
		inc_c = r_c[0] & ((rem_s[N-1] != 57'd0) | r_c[1]);
		sum_c = {1'b0, r_c[53:1]} + 54'(inc_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_ctl <= ctl_s[N-1];
			if (sum_c[53]) begin
				out_s  <= {1'b1, 52'd0};
				out_es <= ex_s[N-1] - 10'sd39;
			end else begin
				out_s  <= sum_c[52:0];
				out_es <= ex_s[N-1] - 10'sd40;
			end
		end
	end

endmodule

@@ rtl/fsr_recip.sv @@
// square root packing, restoring reciprocal divider pipeline and final result select
module fsr_recip (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  fsr_pkg::ctl_t   in_ctl,
	input  logic [52:0]     in_s,
	input  fsr_pkg::exp_t   in_es,
	output logic            out_valid,
	output logic            out_last,
	output logic [31:0]     out_res
);

	localparam int N = fsr_pkg::DIV_STEPS;

	// round a 53-bit significand to 24 bits and attach a biased exponent
	function automatic logic [30:0] pack24(input logic [52:0] s, input fsr_pkg::exp_t be);
		logic        inc;
		logic [24:0] sum;
		logic [9:0]  bex;
		inc = s[28] & ((s[27:0] != 28'd0) | s[29]);
		sum = {1'b0, s[52:29]} + 25'(inc);
		bex = be + 10'(sum[24]);
		return {bex[7:0], sum[24] ? 23'd0 : sum[22:0]};
	endfunction

	logic            v_s1;
	fsr_pkg::ctl_t   ctl_s1;
	logic [52:0]     s_s1;
	fsr_pkg::exp_t   es_s1;
	fsr_pkg::ctl_t   ctl_c;

	// finish square root mode here
	always_comb begin
		ctl_c = in_ctl;
		if (!in_ctl.done && !in_ctl.mode) begin
			ctl_c.res  = {1'b0, pack24(in_s, in_es + 10'sd179)};
			ctl_c.done = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1 <= ctl_c;
			s_s1   <= in_s;
			es_s1  <= in_es;
		end
	end

	logic            v_s   [N];
	fsr_pkg::ctl_t   ctl_s [N];
	logic [52:0]     d_s   [N];
	fsr_pkg::exp_t   es_s  [N];
	logic [54:0]     p_s   [N];
	logic [55:0]     q_s   [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		logic            pv;
		fsr_pkg::ctl_t   pctl;
		logic [52:0]     pd;
		fsr_pkg::exp_t   pes;
		logic [54:0]     pp;
		logic [55:0]     pq;
		logic            ge;
		logic [54:0]     diff;

		if (k == 0) begin : g_first
			assign pv   = v_s1;
			assign pctl = ctl_s1;
			assign pd   = s_s1;
			assign pes  = es_s1;
			assign pp   = 55'd1 << 52;
			assign pq   = '0;
		end else begin : g_next
			assign pv   = v_s[k-1];
			assign pctl = ctl_s[k-1];
			assign pd   = d_s[k-1];
			assign pes  = es_s[k-1];
			assign pp   = p_s[k-1];
			assign pq   = q_s[k-1];
		end

		assign ge   = pp >= {2'b00, pd};
		assign diff = ge ? (pp - {2'b00, pd}) : pp;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (en) begin
				v_s[k] <= pv;
			end
		end

		// one quotient bit per stage
		always_ff @(posedge clk) begin
			if (en) begin
				ctl_s[k] <= pctl;
				d_s[k]   <= pd;
				es_s[k]  <= pes;
				p_s[k]   <= {diff[53:0], 1'b0};
				q_s[k]   <= {pq[54:0], ge};
			end
		end
	end

	logic            v_s2;
	fsr_pkg::ctl_t   ctl_s2;
	logic [52:0]     q53_s2;
	fsr_pkg::exp_t   be_s2;
	logic [55:0]     qf_c;
	logic            inc_c;
	logic [53:0]     sum_c;

	// round the quotient to 53 bits, nearest-even
	always_comb begin
		qf_c  = q_s[N-1];
		inc_c = qf_c[1] & (qf_c[0] | (p_s[N-1] != 55'd0) | qf_c[2]);
		sum_c = {1'b0, qf_c[54:2]} + 54'(inc_c);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s[N-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s2 <= ctl_s[N-1];
			if (qf_c[55] || sum_c[53]) begin
				q53_s2 <= {1'b1, 52'd0};
				be_s2  <= 10'sd75 - es_s[N-1];
			end else begin
				q53_s2 <= sum_c[52:0];
				be_s2  <= 10'sd74 - es_s[N-1];
			end
		end
	end

	// round to single and pick the result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_last <= ctl_s2.last;
			out_res  <= ctl_s2.done ? ctl_s2.res : {1'b0, pack24(q53_s2, be_s2)};
		end
	end

endmodule
